[design/tspg_pkg.sv]
// ----------------------------------------------------------------------------
// tspg_pkg
// Shared types and constants of the three-axis step pulse generator.
// ----------------------------------------------------------------------------
package tspg_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned AXIS_IDX_W = 2;
  localparam logic [AXIS_IDX_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_IDX_W-1:0] AXIS_Z = 2'd2;

  localparam int unsigned POS_W     = 16;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned CNT_W     = 33;
  localparam int unsigned CMP_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned CLOCK_HZ   = 16000000;
  localparam int unsigned PRESCALE   = 8;
  localparam int unsigned HOME_START = 5000;

  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned STEPS_W    = 32;
  localparam int unsigned SQ_W       = 34;
  localparam int unsigned RAD_W      = SQ_W + 16;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SQ_REM_W   = ROOT_W + 2;
  localparam int unsigned SQ_CNT_W   = $clog2(ROOT_W + 1);
  localparam int unsigned LHS_W      = ROOT_W + RATE_W;
  localparam int unsigned DIV_NW     = 56;
  localparam int unsigned DIV_DW     = 40;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_NW + 1);

  localparam logic [1:0] MODE_MOVE = 2'd0;
  localparam logic [1:0] MODE_HOME = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;
  localparam logic [1:0] MODE_NOP  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_FEED     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SPU    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SPU    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SPU    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_POLARITY = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_TICK,
    OP_CAPTURE,
    OP_SQ,
    OP_ACC,
    OP_SQRT_GO,
    OP_MUL_LX,
    OP_MUL_DF,
    OP_CMP,
    OP_MUL_STEPS,
    OP_LATCH_STEPS,
    OP_MUL_RATE,
    OP_RATE,
    OP_TAKE_F,
    OP_MUL_DEN,
    OP_DIV_DEN,
    OP_WRITE,
    OP_FINISH
  } op_e;

  typedef struct packed {
    logic [1:0]          mode;
    logic [POS_W-1:0]    target_x;
    logic [POS_W-1:0]    target_y;
    logic [POS_W-1:0]    target_z;
    logic [NUM_AXES-1:0] home_axes;
    logic [NUM_AXES-1:0] endstop_levels;
  } in_t;

  typedef struct packed {
    logic [NUM_AXES-1:0] step_levels;
    logic [NUM_AXES-1:0] dir_levels;
    logic [NUM_AXES-1:0] running_axes;
    logic                homing_active;
    logic                command_rejected;
  } out_t;

  typedef struct packed {
    op_e                   op;
    logic [AXIS_IDX_W-1:0] idx;
    logic                  out_load;
    logic                  rejected;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                busy;
    logic [NUM_AXES-1:0] d_zero;
    logic                rate_direct;
    logic                f_special;
    logic                sqrt_busy;
    logic                div_busy;
  } dp_status_t;

endpackage

[design/tspg_dp.sv]
// ----------------------------------------------------------------------------
// tspg_dp
// Datapath: axis state, tick timers, shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
module tspg_dp import tspg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  in_t                  in_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  output out_t                 out_o
);

  localparam logic [DIV_NW-1:0] ClockN   = DIV_NW'(CLOCK_HZ);
  localparam logic [DIV_NW-1:0] CmpLimit = DIV_NW'(1) << CMP_W;

  logic [RATE_W-1:0]   feed_q;
  logic [RATE_W-1:0]   max_q [NUM_AXES];
  logic [RATE_W-1:0]   spu_q [NUM_AXES];
  logic [NUM_AXES-1:0] pol_q;

  logic [POS_W-1:0]    pos_q   [NUM_AXES];
  logic [CNT_W-1:0]    hcnt_q  [NUM_AXES];
  logic [CNT_W-1:0]    hcnt_d  [NUM_AXES];
  logic [CNT_W-1:0]    hinc    [NUM_AXES];
  logic [CNT_W-1:0]    hlim_q  [NUM_AXES];
  logic [CMP_W-1:0]    cmp_q   [NUM_AXES];
  logic [CMP_W-1:0]    timer_q [NUM_AXES];
  logic [CMP_W-1:0]    timer_d [NUM_AXES];
  logic [NUM_AXES-1:0] run_q, run_d;
  logic                hom_q, hom_d;
  logic [NUM_AXES-1:0] pulse_q, pulse_d;
  logic [NUM_AXES-1:0] dir_q, dir_d;

  logic [POS_W-1:0]    cap_tgt  [NUM_AXES];
  logic [POS_W-1:0]    cap_base [NUM_AXES];
  logic [POS_W-1:0]    cap_dist [NUM_AXES];
  logic [NUM_AXES-1:0] cap_up;
  logic                cap_home;

  logic [POS_W-1:0]    tgt_q [NUM_AXES];
  logic [POS_W-1:0]    d_q   [NUM_AXES];
  logic [NUM_AXES-1:0] up_q;
  logic                home_cmd_q;
  logic [SQ_W-1:0]     acc_q;
  logic [LHS_W-1:0]    lhs_q;
  logic                bound_q;
  logic [STEPS_W-1:0]  steps_q;
  logic [DIV_NW-1:0]   f_q;

  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   prod, p_q;
  logic                mul_en;

  logic [RAD_W-1:0]    rad_q;
  logic [SQ_REM_W-1:0] srem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [SQ_CNT_W-1:0] scnt_q;
  logic [SQ_REM_W+1:0] srem_sh;
  logic [SQ_REM_W-1:0] strial;

  logic [DIV_NW-1:0]    dnum_q;
  logic [DIV_DW-1:0]    dden_q;
  logic [DIV_DW-1:0]    drem_q;
  logic [DIV_CNT_W-1:0] dcnt_q;
  logic [DIV_DW:0]      drem_sh;
  logic                 div_start;
  logic [DIV_NW-1:0]    div_num;
  logic [DIV_DW-1:0]    div_den;

  logic                rate_direct;
  logic [DIV_NW-1:0]   q_m1;
  logic [CMP_W-1:0]    cmp_new;
  logic [AXIS_IDX_W-1:0] idx;

  out_t out_q;

  assign idx = cmd_i.idx;
  assign cap_home = (in_i.mode == MODE_HOME);
  assign rate_direct = home_cmd_q || (idx == AXIS_Z);

  always_comb begin
    cap_tgt[0] = in_i.target_x;
    cap_tgt[1] = in_i.target_y;
    cap_tgt[2] = in_i.target_z;
    for (int i = 0; i < NUM_AXES; i++) begin
      cap_base[i] = pos_q[i];
      if (cap_home) begin
        cap_tgt[i]  = in_i.home_axes[i] ? '0 : pos_q[i];
        cap_base[i] = in_i.home_axes[i] ? POS_W'(HOME_START) : pos_q[i];
      end
      cap_up[i]   = cap_tgt[i] > cap_base[i];
      cap_dist[i] = cap_up[i] ? cap_tgt[i] - cap_base[i] : cap_base[i] - cap_tgt[i];
    end
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd_i.op)
      OP_SQ: begin
        mul_a = MUL_W'(d_q[idx]);
        mul_b = MUL_W'(d_q[idx]);
      end
      OP_MUL_LX: begin
        mul_a = MUL_W'(root_q);
        mul_b = MUL_W'(max_q[0]);
      end
      OP_MUL_DF: begin
        mul_a = MUL_W'(d_q[0]);
        mul_b = MUL_W'(feed_q);
      end
      OP_MUL_STEPS: begin
        mul_a = MUL_W'(d_q[idx]);
        mul_b = MUL_W'(spu_q[idx]);
      end
      OP_MUL_RATE: begin
        if (rate_direct) begin
          mul_a = MUL_W'(max_q[idx]);
          mul_b = MUL_W'(spu_q[idx]);
        end else if (bound_q) begin
          mul_a = steps_q;
          mul_b = MUL_W'(max_q[0]);
        end else begin
          mul_a = steps_q;
          mul_b = MUL_W'(feed_q);
        end
      end
      OP_MUL_DEN: begin
        mul_a = f_q[MUL_W-1:0];
        mul_b = MUL_W'(2 * PRESCALE);
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_start = 1'b0;
    div_num   = ClockN;
    div_den   = p_q[DIV_DW-1:0];
    if (cmd_i.op == OP_RATE && !rate_direct) begin
      div_start = 1'b1;
      if (bound_q) begin
        div_num = DIV_NW'(p_q[47:0]);
        div_den = DIV_DW'(d_q[0]);
      end else begin
        div_num = {p_q[47:0], 8'd0};
        div_den = DIV_DW'(root_q);
      end
    end else if (cmd_i.op == OP_DIV_DEN) begin
      div_start = 1'b1;
    end
  end

  assign drem_sh = {drem_q, dnum_q[DIV_NW-1]};
  assign srem_sh = {srem_q, rad_q[RAD_W-1 -: 2]};
  assign strial  = {root_q, 2'b01};

  assign q_m1 = dnum_q - DIV_NW'(1);
  always_comb begin
    if (f_q == '0) begin
      cmp_new = '1;
    end else if (f_q > ClockN || dnum_q == '0) begin
      cmp_new = '0;
    end else if (dnum_q > CmpLimit) begin
      cmp_new = '1;
    end else begin
      cmp_new = q_m1[CMP_W-1:0];
    end
  end

  always_comb begin
    run_d   = run_q;
    pulse_d = pulse_q;
    hom_d   = hom_q;
    dir_d   = dir_q;
    for (int i = 0; i < NUM_AXES; i++) begin
      timer_d[i] = timer_q[i];
      hcnt_d[i]  = hcnt_q[i];
      hinc[i]    = hcnt_q[i] + 1'b1;
    end
    unique case (cmd_i.op)
      OP_TICK: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (run_q[i]) begin
            if (timer_q[i] != cmp_q[i]) begin
              timer_d[i] = timer_q[i] + 1'b1;
            end else begin
              timer_d[i] = '0;
              if (hinc[i] > hlim_q[i] || (hom_q && !in_i.endstop_levels[i])) begin
                run_d[i]  = 1'b0;
                hcnt_d[i] = '0;
              end else begin
                hcnt_d[i]  = hinc[i];
                pulse_d[i] = ~pulse_q[i];
              end
            end
          end
        end
        if (run_d == '0) begin
          hom_d = 1'b0;
        end
      end
      OP_WRITE: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (AXIS_IDX_W'(i) == idx) begin
            dir_d[i]   = up_q[i] ? pol_q[i] : ~pol_q[i];
            run_d[i]   = 1'b1;
            pulse_d[i] = 1'b0;
            timer_d[i] = '0;
            hcnt_d[i]  = '0;
          end
        end
      end
      OP_FINISH: begin
        if (home_cmd_q) begin
          hom_d = (run_q != '0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feed_q <= RATE_W'(50);
      pol_q  <= '1;
      for (int i = 0; i < NUM_AXES; i++) begin
        max_q[i] <= RATE_W'(100);
        spu_q[i] <= RATE_W'(80);
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FEED:     feed_q   <= cfg_data_i;
        CFG_X_MAX:    max_q[0] <= cfg_data_i;
        CFG_Y_MAX:    max_q[1] <= cfg_data_i;
        CFG_Z_MAX:    max_q[2] <= cfg_data_i;
        CFG_X_SPU:    spu_q[0] <= cfg_data_i;
        CFG_Y_SPU:    spu_q[1] <= cfg_data_i;
        CFG_Z_SPU:    spu_q[2] <= cfg_data_i;
        CFG_POLARITY: pol_q    <= cfg_data_i[NUM_AXES-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      hom_q   <= 1'b0;
      pulse_q <= '0;
      dir_q   <= '1;
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_q[i]   <= '0;
        hcnt_q[i]  <= '0;
        hlim_q[i]  <= '0;
        cmp_q[i]   <= '0;
        timer_q[i] <= '0;
      end
      scnt_q <= '0;
      dcnt_q <= '0;
    end else begin
      run_q   <= run_d;
      hom_q   <= hom_d;
      pulse_q <= pulse_d;
      dir_q   <= dir_d;
      for (int i = 0; i < NUM_AXES; i++) begin
        hcnt_q[i]  <= hcnt_d[i];
        timer_q[i] <= timer_d[i];
        if (cmd_i.op == OP_WRITE && AXIS_IDX_W'(i) == idx) begin
          pos_q[i]  <= tgt_q[i];
          hlim_q[i] <= {steps_q, 1'b0};
          cmp_q[i]  <= cmp_new;
        end
      end
      if (cmd_i.op == OP_SQRT_GO) begin
        scnt_q <= SQ_CNT_W'(ROOT_W);
      end else if (scnt_q != '0) begin
        scnt_q <= scnt_q - 1'b1;
      end
      if (div_start) begin
        dcnt_q <= DIV_CNT_W'(DIV_NW);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= prod;
    end
    if (cmd_i.out_load) begin
      out_q.step_levels      <= pulse_d;
      out_q.dir_levels       <= dir_d;
      out_q.running_axes     <= run_d;
      out_q.homing_active    <= hom_d;
      out_q.command_rejected <= cmd_i.rejected;
    end
    unique case (cmd_i.op)
      OP_CAPTURE: begin
        for (int i = 0; i < NUM_AXES; i++) begin
          tgt_q[i] <= cap_tgt[i];
          d_q[i]   <= cap_dist[i];
        end
        up_q       <= cap_up;
        home_cmd_q <= cap_home;
        acc_q      <= '0;
      end
      OP_ACC:         acc_q   <= acc_q + SQ_W'(p_q[MUL_W-1:0]);
      OP_MUL_DF:      lhs_q   <= p_q[LHS_W-1:0];
      OP_CMP:         bound_q <= lhs_q < LHS_W'({p_q[MUL_W-1:0], 8'd0});
      OP_LATCH_STEPS: steps_q <= p_q[STEPS_W-1:0];
      OP_RATE: begin
        if (rate_direct) begin
          f_q <= p_q[DIV_NW-1:0];
        end
      end
      OP_TAKE_F:      f_q     <= dnum_q;
      default: ;
    endcase
    if (cmd_i.op == OP_SQRT_GO) begin
      rad_q  <= {acc_q, 16'd0};
      srem_q <= '0;
      root_q <= '0;
    end else if (scnt_q != '0) begin
      rad_q <= rad_q << 2;
      if (srem_sh >= (SQ_REM_W + 2)'(strial)) begin
        srem_q <= SQ_REM_W'(srem_sh - (SQ_REM_W + 2)'(strial));
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        srem_q <= srem_sh[SQ_REM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (div_start) begin
      dnum_q <= div_num;
      dden_q <= div_den;
      drem_q <= '0;
    end else if (dcnt_q != '0) begin
      if (drem_sh >= {1'b0, dden_q}) begin
        drem_q <= DIV_DW'(drem_sh - {1'b0, dden_q});
        dnum_q <= {dnum_q[DIV_NW-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh[DIV_DW-1:0];
        dnum_q <= {dnum_q[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    status_o.busy        = (run_q != '0);
    for (int i = 0; i < NUM_AXES; i++) begin
      status_o.d_zero[i] = (d_q[i] == '0);
    end
    status_o.rate_direct = rate_direct;
    status_o.f_special   = (f_q == '0) || (f_q > ClockN);
    status_o.sqrt_busy   = (scnt_q != '0);
    status_o.div_busy    = (dcnt_q != '0);
  end

  assign out_o = out_q;

endmodule

[design/tspg_ctrl.sv]
// ----------------------------------------------------------------------------
// tspg_ctrl
// Controller: request handshakes and the sequence that starts a motion.
// ----------------------------------------------------------------------------
module tspg_ctrl import tspg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ,
    S_ACC,
    S_SQRT_GO,
    S_SQRT_W,
    S_CMP_A,
    S_CMP_B,
    S_CMP_C,
    S_AXIS,
    S_LATCH,
    S_RATE_MUL,
    S_RATE,
    S_RATE_W,
    S_TAKE,
    S_CHECK,
    S_DEN_GO,
    S_DEN_W,
    S_WRITE,
    S_FINISH
  } state_e;

  state_e                state_q, state_d;
  logic [AXIS_IDX_W-1:0] idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic                  in_fire;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    idx_d          = idx_q;
    cmd_o.op       = OP_NONE;
    cmd_o.idx      = idx_q;
    cmd_o.out_load = 1'b0;
    cmd_o.rejected = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.out_load = 1'b1;
          unique case (mode_i) inside
            MODE_MOVE, MODE_HOME: begin
              if (status_i.busy) begin
                cmd_o.rejected = 1'b1;
              end else begin
                cmd_o.out_load = 1'b0;
                cmd_o.op       = OP_CAPTURE;
                idx_d          = AXIS_X;
                state_d        = S_SQ;
              end
            end
            MODE_TICK: cmd_o.op = OP_TICK;
            default: ;
          endcase
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_ACC;
      end
      S_ACC: begin
        cmd_o.op = OP_ACC;
        if (idx_q == AXIS_Z) begin
          state_d = S_SQRT_GO;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SQ;
        end
      end
      S_SQRT_GO: begin
        cmd_o.op = OP_SQRT_GO;
        state_d  = S_SQRT_W;
      end
      S_SQRT_W: begin
        if (!status_i.sqrt_busy) begin
          state_d = S_CMP_A;
        end
      end
      S_CMP_A: begin
        cmd_o.op = OP_MUL_LX;
        state_d  = S_CMP_B;
      end
      S_CMP_B: begin
        cmd_o.op = OP_MUL_DF;
        state_d  = S_CMP_C;
      end
      S_CMP_C: begin
        cmd_o.op = OP_CMP;
        idx_d    = AXIS_X;
        state_d  = S_AXIS;
      end
      S_AXIS: begin
        if (status_i.d_zero[idx_q]) begin
          if (idx_q == AXIS_Z) begin
            state_d = S_FINISH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          cmd_o.op = OP_MUL_STEPS;
          state_d  = S_LATCH;
        end
      end
      S_LATCH: begin
        cmd_o.op = OP_LATCH_STEPS;
        state_d  = S_RATE_MUL;
      end
      S_RATE_MUL: begin
        cmd_o.op = OP_MUL_RATE;
        state_d  = S_RATE;
      end
      S_RATE: begin
        cmd_o.op = OP_RATE;
        state_d  = status_i.rate_direct ? S_CHECK : S_RATE_W;
      end
      S_RATE_W: begin
        if (!status_i.div_busy) begin
          state_d = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd_o.op = OP_TAKE_F;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.f_special) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.op = OP_MUL_DEN;
          state_d  = S_DEN_GO;
        end
      end
      S_DEN_GO: begin
        cmd_o.op = OP_DIV_DEN;
        state_d  = S_DEN_W;
      end
      S_DEN_W: begin
        if (!status_i.div_busy) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        if (idx_q == AXIS_Z) begin
          state_d = S_FINISH;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_AXIS;
        end
      end
      S_FINISH: begin
        cmd_o.op       = OP_FINISH;
        cmd_o.out_load = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (mode_i == MODE_MOVE || mode_i == MODE_HOME) && !status_i.busy)
      |=> (state_q == S_SQ))
    else $error("accepted command did not start the sequence");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && mode_i == MODE_TICK) |=> out_valid_q)
    else $error("tick request produced no result");

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |-> !out_valid_q)
    else $error("result slot occupied at end of command");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd3)
    else $error("axis index out of range");

endmodule

[design/three_axis_stepper_pulse_generator_core.sv]
// ----------------------------------------------------------------------------
// three_axis_stepper_pulse_generator_core
// Step and direction pulse generator for three stepper axes.
// ----------------------------------------------------------------------------
// Requests enter on the in channel (valid/ready) and each one produces exactly
// one result on the out channel (valid/ready). A result register separates the
// two sides, so a new request is taken while the previous result is still
// waiting, as long as that result is taken in the same cycle.
// Tick, no-operation and rejected move or home requests give their result in
// the cycle after acceptance and can be accepted every cycle while the out
// channel takes each result. A move or home request that starts motion first
// finds the path length: it squares and sums the three axis distances and
// takes a bit-serial square root. Each moving X or Y axis of a move then
// takes two bit-serial divisions, and Z or any homing axis a single one; a
// step frequency of zero or above the clock skips the last division. In is
// not ready until the result of a move or home request is given.
// Configuration writes are always accepted and apply at once, also mid-command.
// While the receiver stalls the out channel, the result holds and in_ready_o
// stays low until that result is taken. Reset clears all axes, positions and
// timers and loads the register defaults; the block is ready right after reset.
// ----------------------------------------------------------------------------
module three_axis_stepper_pulse_generator_core import tspg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tspg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (in_i.mode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tspg_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

endmodule
